// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int KEY_BITS_DEF = 16;
	localparam int TAG_BITS_DEF = 16;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_POP    = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_QUERY  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP,
		CELL_SEARCH,
		CELL_SHIFT
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic used;
		logic ge;
		logic tok;
		logic hit;
		logic live;
		logic tail;
	} cell_flags_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  spq_pkg::cell_cmd_t    cmd,
	input  logic [KEY_BITS-1:0]   op_key,
	input  logic [TAG_BITS-1:0]   op_tag,
	input  logic                  tok_in,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [TAG_BITS-1:0]   left_tag,
	input  logic                  left_used,
	input  logic                  left_ge,
	input  logic [KEY_BITS-1:0]   right_key,
	input  logic [TAG_BITS-1:0]   right_tag,
	input  logic                  right_used,
	output logic [KEY_BITS-1:0]   key,
	output logic [TAG_BITS-1:0]   tag,
	output spq_pkg::cell_flags_t  flags
);

	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                used_q;
	logic                tok_q;
	logic                ge;
	logic                match;
	logic [KEY_BITS-1:0] key_d;
	logic [TAG_BITS-1:0] tag_d;
	logic                used_d;

	assign ge    = used_q & (key_q >= op_key);
	assign match = used_q & (key_q == op_key) & (tag_q == op_tag);

	always_comb begin
		key_d  = key_q;
		tag_d  = tag_q;
		used_d = used_q;
		case (cmd)
			spq_pkg::CELL_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						key_d  = op_key;
						tag_d  = op_tag;
						used_d = 1'b1;
					end else begin
						key_d  = left_key;
						tag_d  = left_tag;
						used_d = left_used;
					end
				end
			end
			spq_pkg::CELL_POP: begin
				key_d  = right_key;
				tag_d  = right_tag;
				used_d = right_used;
			end
			spq_pkg::CELL_SEARCH: begin
				if (tok_q && match) begin
					key_d  = right_key;
					tag_d  = right_tag;
					used_d = right_used;
				end
			end
			spq_pkg::CELL_SHIFT: begin
				if (tok_q) begin
					key_d  = right_key;
					tag_d  = right_tag;
					used_d = right_used;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			used_q <= used_d;
			tok_q  <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
		tag_q <= tag_d;
	end

	assign key        = key_q;
	assign tag        = tag_q;
	assign flags.used = used_q;
	assign flags.ge   = ge;
	assign flags.tok  = tok_q;
	assign flags.hit  = tok_q & match;
	assign flags.live = tok_q & used_q;
	assign flags.tail = tok_q & ~right_used;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: cell chain and its sequencer.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; kind selects insert,
// pop, remove or query, with entry_key and entry_tag as operands.
// Each request produces one result: done is high for exactly one cycle with
// status, head_valid, head_key, head_tag and entry_count, all describing the
// queue after the request. The receiver cannot stall; results must be taken
// in the cycle they are shown.
// Insert, pop and query do not raise busy: on insert every cell compares its key with
// the new key and shifts in parallel, so a new request may follow each cycle
// and the result appears in the cycle after the request is taken.
// Remove walks a token down the cell chain one cell per cycle, first to find
// the matching entry and then to close the gap behind it. How long it holds
// busy is set by the position of the match and the entry count; a search that
// misses on a full queue runs the token off the end of the chain before ending.
// Remove on an empty queue finishes without raising busy.
// Reset empties the queue; no clearing pass is needed since each cell has
// its own valid bit.
module sorted_priority_queue #(
	parameter int DEPTH    = spq_pkg::DEPTH_DEF,
	parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF,
	localparam int CW      = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [KEY_BITS-1:0] entry_key,
	input  logic [TAG_BITS-1:0] entry_tag,
	output logic                done,
	output logic [1:0]          status,
	output logic                head_valid,
	output logic [KEY_BITS-1:0] head_key,
	output logic [TAG_BITS-1:0] head_tag,
	output logic [CW-1:0]       entry_count
);

	spq_pkg::state_t      state_q;
	spq_pkg::state_t      state_d;
	spq_pkg::cell_cmd_t   cmd;
	spq_pkg::status_t     status_d;
	spq_pkg::status_t     status_q;
	logic                 done_d;
	logic                 done_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic [KEY_BITS-1:0]  op_key_q;
	logic [TAG_BITS-1:0]  op_tag_q;
	logic [KEY_BITS-1:0]  op_key;
	logic [TAG_BITS-1:0]  op_tag;
	logic                 accept;
	logic                 seed;
	logic                 tok_run;
	logic                 empty;
	logic                 full;
	logic                 hit_any;
	logic                 live_any;
	logic                 tail_any;

	logic [KEY_BITS-1:0]  cell_key [DEPTH];
	logic [TAG_BITS-1:0]  cell_tag [DEPTH];
	spq_pkg::cell_flags_t flags    [DEPTH];
	logic [DEPTH-1:0]     used_vec;
	logic [DEPTH-1:0]     hit_vec;
	logic [DEPTH-1:0]     live_vec;
	logic [DEPTH-1:0]     tail_vec;

	assign busy    = (state_q != spq_pkg::ST_IDLE);
	assign accept  = start & ~busy;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign tok_run = busy;
	assign op_key  = busy ? op_key_q : entry_key;
	assign op_tag  = busy ? op_tag_q : entry_tag;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [KEY_BITS-1:0] l_key;
			logic [TAG_BITS-1:0] l_tag;
			logic                l_used;
			logic                l_ge;
			logic [KEY_BITS-1:0] r_key;
			logic [TAG_BITS-1:0] r_tag;
			logic                r_used;
			logic                t_in;

			if (i == 0) begin : g_first
				assign l_key  = '0;
				assign l_tag  = '0;
				assign l_used = 1'b0;
				assign l_ge   = 1'b1;
				assign t_in   = seed;
			end else begin : g_inner
				assign l_key  = cell_key[i-1];
				assign l_tag  = cell_tag[i-1];
				assign l_used = flags[i-1].used;
				assign l_ge   = flags[i-1].ge;
				assign t_in   = tok_run & flags[i-1].tok;
			end

			if (i == DEPTH - 1) begin : g_last
				assign r_key  = '0;
				assign r_tag  = '0;
				assign r_used = 1'b0;
			end else begin : g_body
				assign r_key  = cell_key[i+1];
				assign r_tag  = cell_tag[i+1];
				assign r_used = flags[i+1].used;
			end

			spq_cell #(
				.KEY_BITS(KEY_BITS),
				.TAG_BITS(TAG_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.op_key    (op_key),
				.op_tag    (op_tag),
				.tok_in    (t_in),
				.left_key  (l_key),
				.left_tag  (l_tag),
				.left_used (l_used),
				.left_ge   (l_ge),
				.right_key (r_key),
				.right_tag (r_tag),
				.right_used(r_used),
				.key       (cell_key[i]),
				.tag       (cell_tag[i]),
				.flags     (flags[i])
			);

			assign used_vec[i] = flags[i].used;
			assign hit_vec[i]  = flags[i].hit;
			assign live_vec[i] = flags[i].live;
			assign tail_vec[i] = flags[i].tail;
		end
	endgenerate

	assign hit_any  = |hit_vec;
	assign live_any = |live_vec;
	assign tail_any = |tail_vec;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept && spq_pkg::kind_t'(kind) == spq_pkg::KIND_REMOVE && !empty) begin
					state_d = spq_pkg::ST_SEARCH;
				end
			end
			spq_pkg::ST_SEARCH: begin
				if (hit_any) begin
					state_d = tail_any ? spq_pkg::ST_IDLE : spq_pkg::ST_SHIFT;
				end else if (!live_any) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			spq_pkg::ST_SHIFT: begin
				if (tail_any) begin
					state_d = spq_pkg::ST_IDLE;
				end
			end
			default: state_d = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = spq_pkg::CELL_HOLD;
		status_d = spq_pkg::STAT_OK;
		done_d   = 1'b0;
		count_d  = count_q;
		seed     = 1'b0;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (spq_pkg::kind_t'(kind))
						spq_pkg::KIND_INSERT: begin
							done_d = 1'b1;
							if (full) begin
								status_d = spq_pkg::STAT_FULL;
							end else begin
								cmd     = spq_pkg::CELL_INSERT;
								count_d = CW'(count_q + 1'b1);
							end
						end
						spq_pkg::KIND_POP: begin
							done_d = 1'b1;
							if (empty) begin
								status_d = spq_pkg::STAT_EMPTY;
							end else begin
								cmd     = spq_pkg::CELL_POP;
								count_d = CW'(count_q - 1'b1);
							end
						end
						spq_pkg::KIND_REMOVE: begin
							if (empty) begin
								done_d   = 1'b1;
								status_d = spq_pkg::STAT_EMPTY;
							end else begin
								seed = 1'b1;
							end
						end
						spq_pkg::KIND_QUERY: begin
							done_d   = 1'b1;
							status_d = empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
						end
						default: begin
						end
					endcase
				end
			end
			spq_pkg::ST_SEARCH: begin
				cmd = spq_pkg::CELL_SEARCH;
				if (hit_any) begin
					count_d = CW'(count_q - 1'b1);
					done_d  = tail_any;
				end else if (!live_any) begin
					done_d   = 1'b1;
					status_d = spq_pkg::STAT_NOT_FOUND;
				end
			end
			spq_pkg::ST_SHIFT: begin
				cmd    = spq_pkg::CELL_SHIFT;
				done_d = tail_any;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spq_pkg::ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= spq_pkg::STAT_OK;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
			if (done_d) begin
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_key_q <= entry_key;
			op_tag_q <= entry_tag;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign head_valid  = flags[0].used;
	assign head_key    = flags[0].used ? cell_key[0] : '0;
	assign head_tag    = flags[0].used ? cell_tag[0] : '0;
	assign entry_count = count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid == (entry_count != '0))
		else $error("head valid disagrees with entry count");

	a_used_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(used_vec) == int'(count_q)))
		else $error("occupied cells disagree with entry count");

	a_done_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a remove is still running");

endmodule
